>>> hw/rtl/sc2a_pkg.sv
// Shared types, key codes and lookup tables for the set-1 scan decoder.
// No dependencies; every other file of the block uses this package.
package sc2a_pkg;

    // Special scan bytes
    localparam logic [7:0] SC_PREFIX      = 8'hE0;
    localparam logic [7:0] SC_LSHIFT_MAKE = 8'h2A;
    localparam logic [7:0] SC_LSHIFT_BRK  = 8'hAA;
    localparam logic [7:0] SC_LCTRL_MAKE  = 8'h1D;
    localparam logic [7:0] SC_LCTRL_BRK   = 8'h9D;
    localparam logic [7:0] SC_MAX_MAKE    = 8'h3A;

    // Character codes
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_LOW_C  = 8'h63;
    localparam logic [7:0] CH_LOW_D  = 8'h64;
    localparam logic [7:0] CH_EOF    = 8'hFF;

    localparam int unsigned TAB_W = 4;
    localparam int unsigned CNT_W = 3;   // result count minus one, up to 7

    typedef struct packed {
        logic       hit;
        logic [7:0] ch;
    } t_lookup;

    typedef struct packed {
        logic shift_held;
        logic ctrl_held;
        logic prefix_pending;
    } t_mod_state;

    typedef struct packed {
        logic             emit;
        logic [7:0]       out_byte;
        logic             kill_request;
        logic [CNT_W-1:0] extra;       // further results after the first
    } t_decode;

    function automatic t_lookup mk(input logic [7:0] c);
        t_lookup r;
        r.hit = 1'b1;
        r.ch  = c;
        return r;
    endfunction

    // Unshifted make-code table, codes 0x00..0x3A
    function automatic t_lookup lower_map(input logic [7:0] b);
        t_lookup r;
        r = '0;
        case (b)
            8'h01: r = mk(8'h1B);
            8'h02: r = mk(8'h31); 8'h03: r = mk(8'h32); 8'h04: r = mk(8'h33);
            8'h05: r = mk(8'h34); 8'h06: r = mk(8'h35); 8'h07: r = mk(8'h36);
            8'h08: r = mk(8'h37); 8'h09: r = mk(8'h38); 8'h0A: r = mk(8'h39);
            8'h0B: r = mk(8'h30); 8'h0C: r = mk(8'h2D); 8'h0D: r = mk(8'h3D);
            8'h0E: r = mk(8'h08); 8'h0F: r = mk(CH_TAB);
            8'h10: r = mk(8'h71); 8'h11: r = mk(8'h77); 8'h12: r = mk(8'h65);
            8'h13: r = mk(8'h72); 8'h14: r = mk(8'h74); 8'h15: r = mk(8'h79);
            8'h16: r = mk(8'h75); 8'h17: r = mk(8'h69); 8'h18: r = mk(8'h6F);
            8'h19: r = mk(8'h70); 8'h1A: r = mk(8'h5B); 8'h1B: r = mk(8'h5D);
            8'h1C: r = mk(8'h0A);
            8'h1E: r = mk(8'h61); 8'h1F: r = mk(8'h73); 8'h20: r = mk(8'h64);
            8'h21: r = mk(8'h66); 8'h22: r = mk(8'h67); 8'h23: r = mk(8'h68);
            8'h24: r = mk(8'h6A); 8'h25: r = mk(8'h6B); 8'h26: r = mk(8'h6C);
            8'h27: r = mk(8'h3B); 8'h28: r = mk(8'h27); 8'h29: r = mk(8'h7C);
            8'h2C: r = mk(8'h7A); 8'h2D: r = mk(8'h78); 8'h2E: r = mk(8'h63);
            8'h2F: r = mk(8'h76); 8'h30: r = mk(8'h62); 8'h31: r = mk(8'h6E);
            8'h32: r = mk(8'h6D); 8'h33: r = mk(8'h2C); 8'h34: r = mk(8'h2E);
            8'h35: r = mk(8'h2F);
            8'h39: r = mk(CH_SPACE);
            default: r = '0;
        endcase
        return r;
    endfunction

    // Shifted make-code table, codes 0x00..0x3A
    function automatic t_lookup upper_map(input logic [7:0] b);
        t_lookup r;
        r = '0;
        case (b)
            8'h01: r = mk(8'h1B);
            8'h02: r = mk(8'h21); 8'h03: r = mk(8'h40); 8'h04: r = mk(8'h23);
            8'h05: r = mk(8'h24); 8'h06: r = mk(8'h25); 8'h07: r = mk(8'h5E);
            8'h08: r = mk(8'h26); 8'h09: r = mk(8'h2A); 8'h0A: r = mk(8'h28);
            8'h0B: r = mk(8'h29); 8'h0C: r = mk(8'h5F); 8'h0D: r = mk(8'h2B);
            8'h0E: r = mk(8'h08); 8'h0F: r = mk(CH_TAB);
            8'h10: r = mk(8'h51); 8'h11: r = mk(8'h57); 8'h12: r = mk(8'h45);
            8'h13: r = mk(8'h52); 8'h14: r = mk(8'h54); 8'h15: r = mk(8'h59);
            8'h16: r = mk(8'h55); 8'h17: r = mk(8'h49); 8'h18: r = mk(8'h4F);
            8'h19: r = mk(8'h50); 8'h1A: r = mk(8'h7B); 8'h1B: r = mk(8'h7D);
            8'h1C: r = mk(8'h0A);
            8'h1E: r = mk(8'h41); 8'h1F: r = mk(8'h53); 8'h20: r = mk(8'h44);
            8'h21: r = mk(8'h46); 8'h22: r = mk(8'h47); 8'h23: r = mk(8'h48);
            8'h24: r = mk(8'h4A); 8'h25: r = mk(8'h4B); 8'h26: r = mk(8'h4C);
            8'h27: r = mk(8'h3A); 8'h28: r = mk(8'h22);
            8'h2C: r = mk(8'h5A); 8'h2D: r = mk(8'h58); 8'h2E: r = mk(8'h43);
            8'h2F: r = mk(8'h56); 8'h30: r = mk(8'h42); 8'h31: r = mk(8'h4E);
            8'h32: r = mk(8'h4D); 8'h33: r = mk(8'h3C); 8'h34: r = mk(8'h3E);
            8'h35: r = mk(8'h3F);
            8'h39: r = mk(CH_SPACE);
            default: r = '0;
        endcase
        return r;
    endfunction

    // Extended keys after the prefix byte: low byte of the key code
    function automatic t_lookup ext_map(input logic [7:0] b);
        t_lookup r;
        r = '0;
        case (b)
            8'h47: r = mk(8'h07);
            8'h48: r = mk(8'h2C);
            8'h49: r = mk(8'h0A);
            8'h4B: r = mk(8'h2E);
            8'h4D: r = mk(8'h2F);
            8'h4F: r = mk(8'h0B);
            8'h50: r = mk(8'h2D);
            8'h51: r = mk(8'h0C);
            8'h52: r = mk(8'h0D);
            8'h53: r = mk(8'h7F);
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

>>> hw/rtl/sc2a_if.sv
// Handshake channels of the set-1 scan decoder: scan input, character output
// and the tab width write port. Depends on sc2a_pkg for widths.

interface sc2a_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] scan_code;

    modport source (output valid, output scan_code, input ready);
    modport sink   (input valid, input scan_code, output ready);
endinterface

interface sc2a_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       kill_request;
    logic       last;

    modport source (output valid, output out_byte, output kill_request, output last,
                    input ready);
    modport sink   (input valid, input out_byte, input kill_request, input last,
                    output ready);
endinterface

interface sc2a_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [sc2a_pkg::TAB_W-1:0]  tab_width;

    modport source (output valid, output tab_width, input ready);
    modport sink   (input valid, input tab_width, output ready);
endinterface

>>> hw/rtl/scancode_set1_to_ascii_top.sv
// Set-1 scan decoder top level: input register, decode, result register.
// An accepted scan byte goes through the input register and then the result register.
// Throughput: one scan byte per cycle if not stalled; a tab holds its byte in the result
// register for 1 to 8 words (tab_width clamped to 1..8), one space word per ready cycle.
// Reset: synchronous active-low i_rst_n clears modifiers, valids, tab width to 3.
// Depends on sc2a_pkg, sc2a_if.sv and sc2a_decode.
module scancode_set1_to_ascii_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sc2a_in_if.sink     i_in,
    sc2a_cfg_if.sink    i_cfg,
    sc2a_out_if.source  o_out
);
    import sc2a_pkg::*;

    localparam logic [TAB_W-1:0] TAB_RESET = TAB_W'(3);

    logic [TAB_W-1:0] r_tab_width;
    t_mod_state       r_state;
    t_mod_state       n_state;
    logic             r_s1_valid;
    logic [7:0]       r_s1_code;
    logic             r_out_valid;
    logic [7:0]       r_out_byte;
    logic             r_out_kill;
    logic [CNT_W-1:0] r_out_rem;
    t_decode          dec;
    logic             out_fire;
    logic             out_free;
    logic             s1_adv;

    // Configuration port is always open
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tab_width <= TAB_RESET;
        end else if (i_cfg.valid) begin
            r_tab_width <= i_cfg.tab_width;
        end
    end

    sc2a_decode u_decode (
        .i_scan_code (r_s1_code),
        .i_state     (r_state),
        .i_tab_width (r_tab_width),
        .o_state     (n_state),
        .o_dec       (dec)
    );

    // Result register frees when its final word leaves
    assign out_fire = r_out_valid && o_out.ready;
    assign out_free = !r_out_valid || (out_fire && r_out_rem == '0);
    assign s1_adv   = r_s1_valid && out_free;
    assign i_in.ready = !r_s1_valid || s1_adv;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_s1_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_s1_code <= i_in.scan_code;
        end
    end

    // Modifier state moves when the byte is decoded into the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (s1_adv) begin
            r_state <= n_state;
        end
    end

    // Result register with repeat count for tab expansion
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_out_rem   <= '0;
        end else if (s1_adv) begin
            r_out_valid <= dec.emit;
            r_out_rem   <= dec.extra;
        end else if (out_fire && r_out_rem != '0) begin
            r_out_rem   <= r_out_rem - CNT_W'(1);
        end else if (out_fire) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_byte <= dec.out_byte;
            r_out_kill <= dec.kill_request;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.out_byte     = r_out_byte;
    assign o_out.kill_request = r_out_kill;
    assign o_out.last         = (r_out_rem == '0);

endmodule

>>> hw/rtl/sc2a_decode.sv
// Combinational decode of one scan byte against the modifier state.
// Depends on sc2a_pkg for the tables, codes and structs.
module sc2a_decode (
    input  logic [7:0]                 i_scan_code,
    input  sc2a_pkg::t_mod_state       i_state,
    input  logic [sc2a_pkg::TAB_W-1:0] i_tab_width,
    output sc2a_pkg::t_mod_state       o_state,
    output sc2a_pkg::t_decode          o_dec
);
    import sc2a_pkg::*;

    t_lookup          lo;
    t_lookup          up;
    t_lookup          ex;
    t_lookup          key;
    logic [CNT_W-1:0] tab_extra;

    assign lo = lower_map(i_scan_code);
    assign up = upper_map(i_scan_code);
    assign ex = ext_map(i_scan_code);

    // Tab width clamped to 1..8, kept as count minus one
    always_comb begin
        if (i_tab_width == '0) begin
            tab_extra = '0;
        end else if (i_tab_width > TAB_W'(8)) begin
            tab_extra = '1;
        end else begin
            tab_extra = CNT_W'(i_tab_width - TAB_W'(1));
        end
    end

    // Character selection by shift state
    assign key = i_state.shift_held ? up : lo;

    always_comb begin
        o_state = i_state;
        o_dec   = '0;
        if (i_state.prefix_pending) begin
            // The byte after the prefix is only an extended key
            o_state.prefix_pending = 1'b0;
            o_dec.emit             = ex.hit;
            o_dec.out_byte         = ex.ch;
        end else begin
            unique case (i_scan_code)
                SC_LSHIFT_BRK:  o_state.shift_held     = 1'b0;
                SC_LCTRL_BRK:   o_state.ctrl_held      = 1'b0;
                SC_LCTRL_MAKE:  o_state.ctrl_held      = 1'b1;
                SC_LSHIFT_MAKE: o_state.shift_held     = 1'b1;
                SC_PREFIX:      o_state.prefix_pending = 1'b1;
                default: begin
                    // Plain make code; lowercase must map before shift is looked at
                    if (i_scan_code <= SC_MAX_MAKE && lo.hit && key.hit) begin
                        o_dec.emit     = 1'b1;
                        o_dec.out_byte = key.ch;
                        if (!i_state.shift_held && i_state.ctrl_held
                                && lo.ch == CH_LOW_C) begin
                            o_dec.out_byte     = '0;
                            o_dec.kill_request = 1'b1;
                        end else if (!i_state.shift_held && i_state.ctrl_held
                                && lo.ch == CH_LOW_D) begin
                            o_dec.out_byte = CH_EOF;
                        end else if (key.ch == CH_TAB) begin
                            o_dec.out_byte = CH_SPACE;
                            o_dec.extra    = tab_extra;
                        end
                    end
                end
            endcase
        end
    end

endmodule

>>> bench/tb_scancode_set1_to_ascii_top.sv
`timescale 1ns / 100ps
// Self-checking bench for the set-1 scan decoder: scan bytes in, character words out.
// Expected words come from a behavioral decoder kept in step with the block.
// Depends on sc2a_pkg, sc2a_if.sv and scancode_set1_to_ascii_top.

module tb_scancode_set1_to_ascii_top;
    import sc2a_pkg::*;

    localparam int unsigned CLK_HALF       = 5;
    localparam int unsigned DRAIN_CYCLES   = 6;
    localparam int unsigned LONG_HOLD      = 60;
    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned MAX_TAB        = 8;

    localparam logic [7:0] SC_TAB      = 8'h0F;
    localparam logic [7:0] SC_KEY_C    = 8'h2E;
    localparam logic [7:0] SC_KEY_D    = 8'h20;
    localparam logic [7:0] SC_ALT_MAKE = 8'h38;
    localparam logic [7:0] BREAK_BIT   = 8'h80;
    localparam logic [7:0] EXT_FIRST   = 8'h47;
    localparam logic [7:0] EXT_LAST    = 8'h53;
    localparam logic [7:0] NO_CHAR     = "~";
    localparam logic [7:0] NO_EXT      = 8'h00;

    // Character per make code 0x00..0x3A, first code in the top byte; "~" marks no key.
    localparam logic [59*8-1:0] PLAIN_KEYS =
        "~\0331234567890-=\010\tqwertyuiop[]\n~asdfghjkl;'|~~zxcvbnm,./~~~ ~";
    localparam logic [59*8-1:0] SHIFT_KEYS =
        "~\033!@#$%^&*()_+\010\tQWERTYUIOP{}\n~ASDFGHJKL:\"~~~ZXCVBNM<>?~~~ ~";
    // Low byte of the extended key code for prefixed bytes 0x47..0x53.
    localparam logic [13*8-1:0] EXT_KEYS =
        104'h07_2C_0A_00_2E_00_2F_00_0B_2D_0C_0D_7F;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       kill_request;
        logic       last;
    } t_char_word;

    logic clk;
    logic rst_n;

    sc2a_in_if  in_ch ();
    sc2a_out_if out_ch ();
    sc2a_cfg_if cfg_ch ();

    scancode_set1_to_ascii_top dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .i_cfg   (cfg_ch),
        .o_out   (out_ch)
    );

    // Decoder state as the bench sees it.
    logic                 shift_down;
    logic                 ctrl_down;
    logic                 prefix_seen;
    logic [TAB_W-1:0]     tab_setting;

    logic [7:0]  scan_feed [$];
    t_char_word  words_due [$];
    t_char_word  due_word;

    int          send_idle_pct;
    int          sink_idle_pct;
    int          acted_count;
    int          mismatches;
    int          hold_requests;
    int          hold_served;
    int unsigned hold_left;
    int unsigned quiet_cycles;

    initial begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        $display("MISMATCH at %0t: %s got %h expected %h", $time, what, got, want);
        mismatches++;
    endtask

    task automatic push_word(input logic [7:0] ch, input logic kill, input logic is_last);
        t_char_word w;
        w.out_byte     = ch;
        w.kill_request = kill;
        w.last         = is_last;
        words_due.push_back(w);
    endtask

    // Work out the words that one accepted scan byte produces and update the state.
    task automatic decode_scan(input logic [7:0] code);
        logic [7:0]  ch;
        int unsigned spaces;
        if (prefix_seen) begin
            // The byte after the prefix is only ever an extended key.
            prefix_seen = 1'b0;
            if (code >= EXT_FIRST && code <= EXT_LAST) begin
                ch = EXT_KEYS[(12 - (code - EXT_FIRST)) * 8 +: 8];
                if (ch != NO_EXT)
                    push_word(ch, 1'b0, 1'b1);
            end
            return;
        end
        case (code)
            SC_LSHIFT_BRK:  begin shift_down = 1'b0; return; end
            SC_LCTRL_BRK:   begin ctrl_down = 1'b0; return; end
            SC_LCTRL_MAKE:  begin ctrl_down = 1'b1; return; end
            SC_LSHIFT_MAKE: begin shift_down = 1'b1; return; end
            SC_PREFIX:      begin prefix_seen = 1'b1; return; end
            default: ;
        endcase
        if (code > SC_MAX_MAKE)
            return;
        ch = PLAIN_KEYS[(58 - code) * 8 +: 8];
        if (ch == NO_CHAR)
            return;
        // Shift is looked at before ctrl.
        if (shift_down) begin
            ch = SHIFT_KEYS[(58 - code) * 8 +: 8];
            if (ch == NO_CHAR)
                return;
        end else if (ctrl_down && ch == CH_LOW_C) begin
            push_word(8'h00, 1'b1, 1'b1);
            return;
        end else if (ctrl_down && ch == CH_LOW_D) begin
            push_word(CH_EOF, 1'b0, 1'b1);
            return;
        end
        if (ch == CH_TAB) begin
            spaces = (tab_setting == 0) ? 1 : (tab_setting > MAX_TAB) ? MAX_TAB : tab_setting;
            for (int i = 1; i <= spaces; i++)
                push_word(CH_SPACE, 1'b0, i == spaces);
        end else begin
            push_word(ch, 1'b0, 1'b1);
        end
    endtask

    task automatic feed(input logic [7:0] code);
        scan_feed.push_back(code);
        // Plain break codes change nothing, so they do not count as work.
        if (!code[7] || code == SC_LSHIFT_BRK || code == SC_LCTRL_BRK || code == SC_PREFIX)
            acted_count++;
    endtask

    // Mostly well-formed key sequences with random content, some noise.
    task automatic random_burst(input int count);
        int         target;
        int         pick;
        logic [7:0] code;
        target = acted_count + count;
        while (acted_count < target) begin
            pick = $urandom_range(99);
            if (pick < 35) begin
                code = 8'($urandom_range(SC_MAX_MAKE));
                feed(code);
                if ($urandom_range(1))
                    feed(code | BREAK_BIT);
            end else if (pick < 50) begin
                feed(SC_LSHIFT_MAKE);
                repeat ($urandom_range(4, 1))
                    feed(8'($urandom_range(SC_MAX_MAKE)));
                if ($urandom_range(3) != 0)
                    feed(SC_LSHIFT_BRK);
            end else if (pick < 62) begin
                feed(SC_LCTRL_MAKE);
                if ($urandom_range(3) == 0)
                    feed(SC_LSHIFT_MAKE);
                case ($urandom_range(2))
                    0: feed(SC_KEY_C);
                    1: feed(SC_KEY_D);
                    default: feed(8'($urandom_range(SC_MAX_MAKE)));
                endcase
                if ($urandom_range(3) != 0)
                    feed(SC_LCTRL_BRK);
                if ($urandom_range(1))
                    feed(SC_LSHIFT_BRK);
            end else if (pick < 74) begin
                feed(SC_PREFIX);
                if ($urandom_range(4) == 0)
                    feed(8'($urandom_range(255)));
                else
                    feed(8'($urandom_range(EXT_LAST, EXT_FIRST)));
            end else if (pick < 84) begin
                feed(SC_TAB);
            end else begin
                feed(8'($urandom_range(255)));
            end
        end
    endtask

    // Wait until everything sent has been answered, then let the pipeline empty.
    task automatic settle();
        do
            @(posedge clk);
        while (scan_feed.size() != 0 || in_ch.valid || words_due.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_tab_width(input logic [TAB_W-1:0] width);
        cfg_ch.tab_width <= width;
        cfg_ch.valid     <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        tab_setting = width;
    endtask

    // Scan byte driver: takes the next byte from the feed when the channel is free.
    always @(posedge clk) begin
        if (!rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready)
                decode_scan(in_ch.scan_code);
            if (!in_ch.valid || in_ch.ready) begin
                if (scan_feed.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    in_ch.valid     <= 1'b1;
                    in_ch.scan_code <= scan_feed.pop_front();
                end else begin
                    in_ch.valid     <= 1'b0;
                    in_ch.scan_code <= 8'($urandom_range(255));
                end
            end
        end
    end

    // Character word monitor: checks each word and drives ready, with long holds on request.
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ch.ready <= 1'b0;
            hold_left    <= 0;
            hold_served  <= 0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (words_due.size() == 0) begin
                    report_mismatch("word with nothing due, out_byte", out_ch.out_byte, 8'h00);
                end else begin
                    due_word = words_due.pop_front();
                    if (out_ch.out_byte !== due_word.out_byte)
                        report_mismatch("out_byte", out_ch.out_byte, due_word.out_byte);
                    if (out_ch.kill_request !== due_word.kill_request)
                        report_mismatch("kill_request", 8'(out_ch.kill_request),
                                        8'(due_word.kill_request));
                    if (out_ch.last !== due_word.last)
                        report_mismatch("last", 8'(out_ch.last), 8'(due_word.last));
                end
            end
            if (hold_served != hold_requests) begin
                hold_served  <= hold_requests;
                hold_left    <= LONG_HOLD;
                out_ch.ready <= 1'b0;
            end else if (hold_left != 0) begin
                hold_left    <= hold_left - 1;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
            end
        end
    end

    // Watchdog: ends the run when no channel has moved a word for too long.
    always @(posedge clk) begin
        if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Stimulus sequence.
    initial begin
        in_ch.valid      = 1'b0;
        in_ch.scan_code  = 8'h00;
        cfg_ch.valid     = 1'b0;
        cfg_ch.tab_width = '0;
        out_ch.ready     = 1'b0;
        rst_n            = 1'b0;
        shift_down       = 1'b0;
        ctrl_down        = 1'b0;
        prefix_seen      = 1'b0;
        tab_setting      = TAB_W'(3);
        send_idle_pct    = 8;
        sink_idle_pct    = 47;
        acted_count      = 0;
        mismatches       = 0;
        hold_requests    = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at the widest tab setting.
        write_tab_width(TAB_W'(MAX_TAB));
        feed(8'h01);            // escape
        feed(8'h02);            // digit one
        feed(SC_TAB);           // a full row of spaces
        feed(8'h00);            // codes without a table entry
        feed(8'h37);
        feed(8'hFF);            // beyond the make table
        feed(SC_LSHIFT_MAKE);
        feed(8'h1E);            // shifted letter
        feed(8'h29);            // no shifted character
        feed(SC_TAB);           // tab under shift still expands
        feed(SC_LCTRL_MAKE);
        feed(SC_KEY_C);         // shift wins over ctrl
        feed(SC_LSHIFT_BRK);
        feed(SC_KEY_C);         // kill request
        feed(SC_KEY_D);         // end of file byte
        feed(SC_LCTRL_BRK);
        feed(SC_PREFIX);
        feed(EXT_FIRST);
        feed(SC_PREFIX);
        feed(8'h4A);            // hole in the extended table
        feed(SC_PREFIX);
        feed(SC_LSHIFT_MAKE);   // eaten by the prefix, shift stays released
        feed(8'h1E);
        feed(SC_PREFIX);
        feed(EXT_LAST);
        feed(SC_PREFIX);
        feed(SC_PREFIX);        // second prefix is eaten by the first
        feed(SC_ALT_MAKE);
        settle();

        write_tab_width(TAB_W'(1));
        random_burst(50);
        settle();

        send_idle_pct = 47;
        sink_idle_pct = 8;
        write_tab_width(TAB_W'(0));
        random_burst(50);
        settle();

        send_idle_pct = 0;
        sink_idle_pct = 0;
        write_tab_width(TAB_W'(15));
        random_burst(50);
        settle();

        // Output held off for a long stretch while the driver keeps offering bytes.
        write_tab_width(TAB_W'($urandom_range(7, 2)));
        hold_requests <= hold_requests + 1;
        random_burst(50);
        settle();

        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/sc2a_pkg.sv
hw/rtl/sc2a_if.sv
hw/rtl/sc2a_decode.sv
hw/rtl/scancode_set1_to_ascii_top.sv
bench/tb_scancode_set1_to_ascii_top.sv
